/* src/omhp_pkg.sv */
// ----------------------------------------------------------------------------
// OSC message header parser package
// Shared constants and types for the header parser and its checker.
// ----------------------------------------------------------------------------
package omhp_pkg;

   localparam logic [15:0] MAX_MSG_BYTES = 16'hFFFF;

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [2:0] ADDR_OFS_PREFIX = 3'd4;
   localparam logic [2:0] ADDR_OFS_NONE   = 3'd0;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TOOSMALL  = 3'd1;
   localparam logic [2:0] ST_MALFORMED = 3'd2;
   localparam logic [2:0] ST_TRUNC     = 3'd3;
   localparam logic [2:0] ST_TOOLONG   = 3'd4;

   typedef enum logic [7:0] {
      PH_FIRST  = 8'b0000_0001,
      PH_PREFIX = 8'b0000_0010,
      PH_ADDR   = 8'b0000_0100,
      PH_APAD   = 8'b0000_1000,
      PH_TAGCHK = 8'b0001_0000,
      PH_TAGS   = 8'b0010_0000,
      PH_TPAD   = 8'b0100_0000,
      PH_DONE   = 8'b1000_0000
   } phase_type;

endpackage

/* src/osc_message_header_parser.sv */
// ----------------------------------------------------------------------------
// OSC message header parser
// Scans an OSC message one byte per beat and reports prefix, address,
// typetag and argument offsets with a status on the final byte.
// ----------------------------------------------------------------------------
// The result is registered and appears on rsp_ in the cycle after the final byte's beat.
// Throughput: one byte per cycle when not stalled; the parse state updates in a single pass.
// Input stalls only while a finished result is held and rsp_stall is high.
// Reset: synchronous, active high; clears parse state and the result valid.
// ----------------------------------------------------------------------------
module osc_message_header_parser
   import omhp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_has_prefix,
   output logic [15:0] rsp_total_bytes,
   output logic [2:0]  rsp_address_offset,
   output logic        rsp_has_typetags,
   output logic [15:0] rsp_typetag_offset,
   output logic [15:0] rsp_arg_count,
   output logic [15:0] rsp_args_offset
);

   phase_type   phase_ff, phase_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [31:0] prefix_word_ff, prefix_word_in;
   logic        prefix_seen_ff, prefix_seen_in;
   logic [2:0]  error_code_ff, error_code_in;
   logic [15:0] tag_start_ff, tag_start_in;
   logic [15:0] tag_count_ff, tag_count_in;
   logic [15:0] data_start_ff, data_start_in;
   logic        tags_found_ff, tags_found_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic        has_prefix_ff;
   logic [15:0] total_bytes_ff;
   logic        has_typetags_ff;
   logic [15:0] typetag_offset_ff;
   logic [15:0] arg_count_ff;
   logic [15:0] args_offset_ff;

   logic        req_take;
   logic        rsp_load;
   logic        nxt_aligned;
   logic [15:0] aligned_next;

   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign req_take    = req_valid & ~req_stall;
   assign rsp_load    = req_take & req_is_last;
   assign nxt_aligned = (byte_count_ff[1:0] == 2'd3);
   assign aligned_next = (byte_count_ff + 16'd4) & ~16'd3;

   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      prefix_word_in = prefix_word_ff;
      prefix_seen_in = prefix_seen_ff;
      error_code_in  = error_code_ff;
      tag_start_in   = tag_start_ff;
      tag_count_in   = tag_count_ff;
      data_start_in  = data_start_ff;
      tags_found_in  = tags_found_ff;

      if (byte_count_ff >= MAX_MSG_BYTES) begin
         if (error_code_ff == ST_OK) begin
            error_code_in = ST_TOOLONG;
         end
      end else begin
         byte_count_in = byte_count_ff + 16'd1;
         if (error_code_ff == ST_OK) begin
            unique case (phase_ff)
               PH_FIRST: begin
                  prefix_word_in = {24'd0, req_data_byte};
                  phase_in = (req_data_byte == CHAR_SLASH) ? PH_ADDR : PH_PREFIX;
               end
               PH_PREFIX: begin
                  if (byte_count_ff < 16'd4) begin
                     prefix_word_in = {prefix_word_ff[23:0], req_data_byte};
                  end else if (req_data_byte == CHAR_SLASH) begin
                     prefix_seen_in = 1'b1;
                     if (prefix_word_ff == 32'd0 || prefix_word_ff[31]) begin
                        error_code_in = ST_TOOSMALL;
                     end else begin
                        phase_in = PH_ADDR;
                     end
                  end else begin
                     error_code_in = ST_MALFORMED;
                  end
               end
               PH_ADDR: begin
                  if (req_data_byte == CHAR_NUL) begin
                     phase_in = nxt_aligned ? PH_TAGCHK : PH_APAD;
                  end
               end
               PH_APAD: begin
                  if (nxt_aligned) begin
                     phase_in = PH_TAGCHK;
                  end
               end
               PH_TAGCHK: begin
                  if (req_data_byte == CHAR_COMMA) begin
                     tags_found_in = 1'b1;
                     tag_start_in  = byte_count_ff;
                     tag_count_in  = 16'd0;
                     phase_in      = PH_TAGS;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_TAGS: begin
                  if (req_data_byte != CHAR_NUL) begin
                     tag_count_in = tag_count_ff + 16'd1;
                  end else if (tag_count_ff == 16'd0) begin
                     phase_in = PH_DONE;
                  end else begin
                     data_start_in = aligned_next;
                     phase_in = nxt_aligned ? PH_DONE : PH_TPAD;
                  end
               end
               PH_TPAD: begin
                  if (nxt_aligned) begin
                     phase_in = PH_DONE;
                  end
               end
               PH_DONE: begin
               end
               default: begin
               end
            endcase
         end
      end

      if (error_code_in != ST_OK) begin
         status_in = error_code_in;
      end else if (phase_in == PH_DONE || phase_in == PH_TAGCHK) begin
         status_in = ST_OK;
      end else begin
         status_in = ST_TRUNC;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // advance parse state; restart on the final beat
   always_ff @(posedge clock) begin
      if (reset || rsp_load) begin
         phase_ff       <= PH_FIRST;
         byte_count_ff  <= 16'd0;
         prefix_word_ff <= 32'd0;
         prefix_seen_ff <= 1'b0;
         error_code_ff  <= ST_OK;
         tag_start_ff   <= 16'd0;
         tag_count_ff   <= 16'd0;
         data_start_ff  <= 16'd0;
         tags_found_ff  <= 1'b0;
      end else if (req_take) begin
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         prefix_word_ff <= prefix_word_in;
         prefix_seen_ff <= prefix_seen_in;
         error_code_ff  <= error_code_in;
         tag_start_ff   <= tag_start_in;
         tag_count_ff   <= tag_count_in;
         data_start_ff  <= data_start_in;
         tags_found_ff  <= tags_found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result beat until taken
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         status_ff         <= status_in;
         has_prefix_ff     <= prefix_seen_in;
         total_bytes_ff    <= byte_count_in;
         has_typetags_ff   <= tags_found_in;
         typetag_offset_ff <= tag_start_in;
         arg_count_ff      <= tag_count_in;
         args_offset_ff    <= data_start_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_has_prefix     = has_prefix_ff;
   assign rsp_total_bytes    = total_bytes_ff;
   assign rsp_address_offset = has_prefix_ff ? ADDR_OFS_PREFIX : ADDR_OFS_NONE;
   assign rsp_has_typetags   = has_typetags_ff;
   assign rsp_typetag_offset = typetag_offset_ff;
   assign rsp_arg_count      = arg_count_ff;
   assign rsp_args_offset    = args_offset_ff;

endmodule

/* src/omhp_checker.sv */
// ----------------------------------------------------------------------------
// OSC message header parser checker
// Port-level assertions on the result channel and the input stall, bound to the parser.
// ----------------------------------------------------------------------------
module omhp_checker
   import omhp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic        rsp_has_prefix,
   input logic [2:0]  rsp_address_offset,
   input logic        rsp_has_typetags,
   input logic [15:0] rsp_typetag_offset,
   input logic [15:0] rsp_arg_count,
   input logic [15:0] rsp_args_offset
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a pending result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_TOOSMALL ||
                    rsp_status == ST_MALFORMED || rsp_status == ST_TRUNC ||
                    rsp_status == ST_TOOLONG)
      else $error("status code out of range");

   a_addr_ofs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_address_offset ==
                    (rsp_has_prefix ? ADDR_OFS_PREFIX : ADDR_OFS_NONE))
      else $error("address offset disagrees with prefix flag");

   a_no_tags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_typetags |->
         rsp_typetag_offset == 16'd0 && rsp_arg_count == 16'd0 &&
         rsp_args_offset == 16'd0)
      else $error("typetag fields set without typetags");

endmodule

bind osc_message_header_parser omhp_checker u_omhp_checker (.*);
